>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// assertion helpers used by esc_back; empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

>>> hw/rtl/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// shared types, constants and arithmetic helpers of the compensation block
// ----------------------------------------------------------------------------
package esc_pkg;

    localparam int QDEPTH = 128;
    localparam int QA_W   = $clog2(QDEPTH);
    localparam int CNT_W  = $clog2(QDEPTH + 1);
    localparam int NFR    = 16;
    localparam int NDV    = 65;
    localparam int NPO    = 6;

    localparam logic [31:0] T_RND      = 32'd128;
    localparam logic [63:0] FINE_P_OFS = 64'd128000;
    localparam logic [31:0] FINE_H_OFS = 32'd76800;
    localparam logic [63:0] P_ADC_OFS  = 64'd1048576;
    localparam logic [63:0] P_SCALE    = 64'd3125;
    localparam logic [63:0] P_BIAS     = 64'd1 << 47;
    localparam logic [63:0] P_RND      = 64'd255;
    localparam logic [31:0] H_RND_A    = 32'd16384;
    localparam logic [31:0] H_OFS_B    = 32'd32768;
    localparam logic [31:0] H_OFS_C    = 32'd2097152;
    localparam logic [31:0] H_RND_C    = 32'd8192;
    localparam logic [31:0] HUM_MAX    = 32'd419430400;
    localparam logic [23:0] HUM_SCALE  = 24'd100;

    typedef enum logic [2:0] {
        REG_TEMP     = 3'd0,
        REG_PRESS_LO = 3'd1,
        REG_PRESS_HI = 3'd2,
        REG_MIXED    = 3'd3,
        REG_HUM      = 3'd4,
        REG_HUM_EN   = 3'd5,
        REG_READY    = 3'd6
    } t_reg;

    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
        logic [7:0]  h1;
        logic [15:0] h2;
        logic [7:0]  h3;
        logic [15:0] h4;
        logic [15:0] h5;
        logic [7:0]  h6;
        logic        hum_en;
        logic        ready;
    } t_coef;

    typedef struct packed {
        logic [15:0] adc_h;
        logic [19:0] adc_t;
        logic [19:0] adc_p;
    } t_in;

    typedef struct packed {
        logic [19:0] adc_p;
        logic [19:0] adc_t;
        logic [15:0] adc_h;
        logic [31:0] ta;
        logic [31:0] td;
        logic [31:0] fine;
        logic [31:0] temp;
        logic [31:0] hx;
        logic [31:0] ha;
        logic [31:0] hb;
        logic [31:0] hc;
        logic [13:0] hum;
        logic [63:0] pu;
        logic [63:0] puu;
        logic [63:0] pup5;
        logic [63:0] pup2;
        logic [63:0] pv6;
        logic [63:0] pv3;
        logic [63:0] pv;
        logic [63:0] puw;
        logic [63:0] pm;
        logic [63:0] num;
        logic [63:0] den;
    } t_fr;

    typedef struct packed {
        logic [31:0] temp;
        logic [13:0] hum;
        logic [63:0] num;
        logic [63:0] den;
    } t_dvin;

    typedef struct packed {
        logic [31:0] temp;
        logic [13:0] hum;
        logic        neg;
        logic        dz;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] b;
    } t_dv;

    typedef struct packed {
        logic [31:0] temp;
        logic [13:0] hum;
        logic        dz;
        logic [63:0] p;
        logic [63:0] a13;
        logic [63:0] p8p;
        logic [63:0] t9;
        logic [63:0] v;
        logic [63:0] pl;
        logic [31:0] pm1;
        logic [31:0] pm2;
        logic [63:0] uu;
        logic [63:0] s;
    } t_po;

    typedef struct packed {
        logic        status;
        logic [13:0] hum;
        logic [31:0] press;
        logic [31:0] temp;
    } t_res;

    function automatic logic [31:0] asr32(input logic [31:0] x, input logic [5:0] n);
        logic signed [31:0] s;
        s = x;
        return s >>> n;
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] x, input logic [6:0] n);
        logic signed [63:0] s;
        s = x;
        return s >>> n;
    endfunction

    function automatic logic [31:0] sx16_32(input logic [15:0] x);
        return {{16{x[15]}}, x};
    endfunction

    function automatic logic [63:0] sx16_64(input logic [15:0] x);
        return {{48{x[15]}}, x};
    endfunction

    function automatic logic [31:0] sx8_32(input logic [7:0] x);
        return {{24{x[7]}}, x};
    endfunction

    function automatic logic [63:0] sx32_64(input logic [31:0] x);
        return {{32{x[31]}}, x};
    endfunction

    function automatic logic [63:0] smul34(input logic [33:0] a, input logic [33:0] b);
        logic signed [33:0] sa;
        logic signed [33:0] sb;
        logic signed [67:0] p;
        sa = a;
        sb = b;
        p  = sa * sb;
        return p[63:0];
    endfunction

    function automatic logic [63:0] smul34x16(input logic [33:0] a, input logic [15:0] b);
        logic signed [33:0] sa;
        logic signed [15:0] sb;
        logic signed [63:0] p;
        sa = a;
        sb = b;
        p  = sa * sb;
        return p;
    endfunction

    function automatic logic [63:0] mul64x16(input logic [63:0] a, input logic [15:0] b);
        logic signed [63:0] sa;
        logic signed [15:0] sb;
        logic signed [63:0] p;
        sa = a;
        sb = b;
        p  = sa * sb;
        return p;
    endfunction

endpackage

>>> hw/rtl/esc_ram.sv
// ----------------------------------------------------------------------------
// esc_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module esc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/esc_front.sv
// ----------------------------------------------------------------------------
// esc_front
// input stage, temperature and humidity pipelines, pressure up to the divide
// ----------------------------------------------------------------------------
module esc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_v,
    input  esc_pkg::t_in   i_data,
    input  esc_pkg::t_coef i_coef,
    output logic           o_v,
    output esc_pkg::t_dvin o_data
);
    import esc_pkg::*;

    t_fr         r_st [NFR];
    t_fr         n_st [NFR];
    logic [NFR-1:0] r_v;
    logic [31:0] hs;
    logic [23:0] hp;

    always_comb begin
        hs = '0;
        hp = '0;
        n_st[0]       = '0;
        n_st[0].adc_p = i_data.adc_p;
        n_st[0].adc_t = i_data.adc_t;
        n_st[0].adc_h = i_data.adc_h;
        for (int k = 1; k < NFR; k++) begin
            n_st[k] = r_st[k-1];
            case (k)
                1: begin
                    n_st[k].ta = {15'd0, r_st[k-1].adc_t[19:3]} - {15'd0, i_coef.t1, 1'b0};
                    n_st[k].td = {16'd0, r_st[k-1].adc_t[19:4]} - {16'd0, i_coef.t1};
                end
                2: begin
                    n_st[k].ta = r_st[k-1].ta * sx16_32(i_coef.t2);
                    n_st[k].td = r_st[k-1].td * r_st[k-1].td;
                end
                3: begin
                    n_st[k].ta = asr32(r_st[k-1].ta, 6'd11);
                    n_st[k].td = asr32(r_st[k-1].td, 6'd12) * sx16_32(i_coef.t3);
                end
                4: begin
                    n_st[k].fine = r_st[k-1].ta + asr32(r_st[k-1].td, 6'd14);
                end
                5: begin
                    n_st[k].temp = asr32(r_st[k-1].fine * 32'd5 + T_RND, 6'd8);
                    n_st[k].pu   = sx32_64(r_st[k-1].fine) - FINE_P_OFS;
                    n_st[k].hx   = r_st[k-1].fine - FINE_H_OFS;
                end
                6: begin
                    n_st[k].ha   = {2'd0, r_st[k-1].adc_h, 14'd0}
                                 - (sx16_32(i_coef.h4) << 20) + H_RND_A;
                    n_st[k].hb   = sx16_32(i_coef.h5) * r_st[k-1].hx;
                    n_st[k].hc   = r_st[k-1].hx * sx8_32(i_coef.h6);
                    n_st[k].td   = r_st[k-1].hx * {24'd0, i_coef.h3};
                    n_st[k].puu  = smul34(r_st[k-1].pu[33:0], r_st[k-1].pu[33:0]);
                    n_st[k].pup5 = smul34x16(r_st[k-1].pu[33:0], i_coef.p5);
                    n_st[k].pup2 = smul34x16(r_st[k-1].pu[33:0], i_coef.p2);
                end
                7: begin
                    n_st[k].ha  = asr32(r_st[k-1].ha - r_st[k-1].hb, 6'd15);
                    n_st[k].hb  = asr32(r_st[k-1].hc, 6'd10);
                    n_st[k].hc  = asr32(r_st[k-1].td, 6'd11) + H_OFS_B;
                    n_st[k].pv6 = mul64x16(r_st[k-1].puu, i_coef.p6);
                    n_st[k].pv3 = mul64x16(r_st[k-1].puu, i_coef.p3);
                end
                8: begin
                    n_st[k].hb  = r_st[k-1].hb * r_st[k-1].hc;
                    n_st[k].pv  = r_st[k-1].pv6 + (r_st[k-1].pup5 << 17)
                                + (sx16_64(i_coef.p4) << 35);
                    n_st[k].puw = asr64(r_st[k-1].pv3, 7'd8) + (r_st[k-1].pup2 << 12);
                end
                9: begin
                    n_st[k].hb  = asr32(r_st[k-1].hb, 6'd10) + H_OFS_C;
                    n_st[k].pm  = (P_BIAS + r_st[k-1].puw) * {48'd0, i_coef.p1};
                    n_st[k].num = ((P_ADC_OFS - {44'd0, r_st[k-1].adc_p}) << 31)
                                - r_st[k-1].pv;
                end
                10: begin
                    n_st[k].hb  = r_st[k-1].hb * sx16_32(i_coef.h2) + H_RND_C;
                    n_st[k].den = asr64(r_st[k-1].pm, 7'd33);
                    n_st[k].num = r_st[k-1].num * P_SCALE;
                end
                11: begin
                    n_st[k].hx = r_st[k-1].ha * asr32(r_st[k-1].hb, 6'd14);
                end
                12: begin
                    n_st[k].hb = asr32(r_st[k-1].hx, 6'd15) * asr32(r_st[k-1].hx, 6'd15);
                end
                13: begin
                    n_st[k].hb = asr32(r_st[k-1].hb, 6'd7) * {24'd0, i_coef.h1};
                end
                14: begin
                    hs = r_st[k-1].hx - asr32(r_st[k-1].hb, 6'd4);
                    if (hs[31]) begin
                        n_st[k].hc = '0;
                    end else if (hs > HUM_MAX) begin
                        n_st[k].hc = HUM_MAX;
                    end else begin
                        n_st[k].hc = hs;
                    end
                end
                15: begin
                    hp = {7'd0, r_st[k-1].hc[28:12]} * HUM_SCALE;
                    n_st[k].hum = hp[23:10];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[NFR-2:0], i_v};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NFR; k++) begin
            r_st[k] <= n_st[k];
        end
    end

    assign o_v         = r_v[NFR-1];
    assign o_data.temp = r_st[NFR-1].temp;
    assign o_data.hum  = r_st[NFR-1].hum;
    assign o_data.num  = r_st[NFR-1].num;
    assign o_data.den  = r_st[NFR-1].den;

endmodule

>>> hw/rtl/esc_div.sv
// ----------------------------------------------------------------------------
// esc_div
// pipelined signed 64-bit divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module esc_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_v,
    input  esc_pkg::t_dvin i_data,
    output logic           o_v,
    output esc_pkg::t_dv   o_data
);
    import esc_pkg::*;

    t_dv         r_st [NDV];
    t_dv         n_st [NDV];
    logic [NDV-1:0] r_v;
    logic [64:0] rs;

    always_comb begin
        rs = '0;
        n_st[0].temp = i_data.temp;
        n_st[0].hum  = i_data.hum;
        n_st[0].neg  = i_data.num[63] ^ i_data.den[63];
        n_st[0].dz   = (i_data.den == '0);
        n_st[0].q    = i_data.num[63] ? (64'd0 - i_data.num) : i_data.num;
        n_st[0].b    = i_data.den[63] ? (64'd0 - i_data.den) : i_data.den;
        n_st[0].r    = '0;
        for (int k = 1; k < NDV; k++) begin
            n_st[k]   = r_st[k-1];
            rs        = {r_st[k-1].r, r_st[k-1].q[63]};
            n_st[k].q = {r_st[k-1].q[62:0], 1'b0};
            if (rs >= {1'b0, r_st[k-1].b}) begin
                rs           = rs - {1'b0, r_st[k-1].b};
                n_st[k].q[0] = 1'b1;
            end
            n_st[k].r = rs[63:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[NDV-2:0], i_v};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NDV; k++) begin
            r_st[k] <= n_st[k];
        end
    end

    assign o_v    = r_v[NDV-1];
    assign o_data = r_st[NDV-1];

endmodule

>>> hw/rtl/esc_post.sv
// ----------------------------------------------------------------------------
// esc_post
// pressure correction after the divide and assembly of the result
// ----------------------------------------------------------------------------
module esc_post (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_v,
    input  esc_pkg::t_dv   i_data,
    input  esc_pkg::t_coef i_coef,
    output logic           o_v,
    output esc_pkg::t_res  o_data
);
    import esc_pkg::*;

    t_po         r_st [NPO];
    t_po         n_st [NPO];
    logic [NPO-1:0] r_v;
    logic        r_ov;
    t_res        r_res;
    t_res        n_res;
    logic [63:0] res;

    always_comb begin
        n_st[0]      = '0;
        n_st[0].temp = i_data.temp;
        n_st[0].hum  = i_data.hum;
        n_st[0].dz   = i_data.dz;
        n_st[0].p    = i_data.neg ? (64'd0 - i_data.q) : i_data.q;
        for (int k = 1; k < NPO; k++) begin
            n_st[k] = r_st[k-1];
            case (k)
                1: begin
                    n_st[k].a13 = asr64(r_st[k-1].p, 7'd13);
                    n_st[k].p8p = mul64x16(r_st[k-1].p, i_coef.p8);
                end
                2: begin
                    n_st[k].t9 = mul64x16(r_st[k-1].a13, i_coef.p9);
                    n_st[k].v  = asr64(r_st[k-1].p8p, 7'd19);
                end
                3: begin
                    n_st[k].pl  = r_st[k-1].t9[31:0] * r_st[k-1].a13[31:0];
                    n_st[k].pm1 = r_st[k-1].t9[31:0] * r_st[k-1].a13[63:32];
                    n_st[k].pm2 = r_st[k-1].t9[63:32] * r_st[k-1].a13[31:0];
                end
                4: begin
                    n_st[k].uu = r_st[k-1].pl + {r_st[k-1].pm1 + r_st[k-1].pm2, 32'd0};
                end
                5: begin
                    n_st[k].s = asr64(r_st[k-1].p + asr64(r_st[k-1].uu, 7'd25)
                                + r_st[k-1].v, 7'd8) + (sx16_64(i_coef.p7) << 4);
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_st[NPO-1].s[63]) begin
            res = asr64(r_st[NPO-1].s + P_RND, 7'd8);
        end else begin
            res = r_st[NPO-1].s >> 8;
        end
        n_res.status = 1'b0;
        n_res.temp   = r_st[NPO-1].temp;
        n_res.press  = r_st[NPO-1].dz ? 32'd0 : res[31:0];
        n_res.hum    = i_coef.hum_en ? r_st[NPO-1].hum : 14'd0;
        if (!i_coef.ready) begin
            n_res = '0;
            n_res.status = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else begin
            r_v  <= {r_v[NPO-2:0], i_v};
            r_ov <= r_v[NPO-1];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NPO; k++) begin
            r_st[k] <= n_st[k];
        end
        r_res <= n_res;
    end

    assign o_v    = r_ov;
    assign o_data = r_res;

endmodule

>>> hw/rtl/esc_back.sv
// ----------------------------------------------------------------------------
// esc_back
// result queue with credit count, ram read prefetch and output skid
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module esc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_acc,
    input  logic          i_wr_valid,
    input  esc_pkg::t_res i_wr_data,
    output logic          o_room,
    output logic          o_tvalid,
    input  logic          i_tready,
    output esc_pkg::t_res o_data
);
    import esc_pkg::*;

    logic [QA_W-1:0]  r_wptr;
    logic [QA_W-1:0]  r_rptr;
    logic [CNT_W-1:0] r_ram_cnt;
    logic [CNT_W-1:0] r_cnt;
    logic             r_rd_pend;
    logic             r_ov;
    logic             r_sv;
    logic             n_ov;
    logic             n_sv;
    t_res             r_out;
    t_res             r_skid;
    t_res             n_out;
    t_res             n_skid;
    t_res             ram_q;
    logic             pop;
    logic             rd_en;
    logic [1:0]       occ;

    esc_ram #(
        .WIDTH ($bits(t_res)),
        .DEPTH (QDEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr_valid),
        .i_waddr (r_wptr),
        .i_wdata (i_wr_data),
        .i_re    (rd_en),
        .i_raddr (r_rptr),
        .o_rdata (ram_q)
    );

    assign pop   = r_ov & i_tready;
    assign occ   = {1'b0, r_ov} + {1'b0, r_sv} + {1'b0, r_rd_pend};
    assign rd_en = (r_ram_cnt != '0) && ((occ - {1'b0, pop}) < 2'd2);

    always_comb begin
        n_ov   = r_ov;
        n_sv   = r_sv;
        n_out  = r_out;
        n_skid = r_skid;
        if (!r_ov || pop) begin
            if (r_sv) begin
                n_out  = r_skid;
                n_ov   = 1'b1;
                n_sv   = r_rd_pend;
                n_skid = ram_q;
            end else if (r_rd_pend) begin
                n_out = ram_q;
                n_ov  = 1'b1;
            end else begin
                n_ov = 1'b0;
            end
        end else if (r_rd_pend) begin
            n_skid = ram_q;
            n_sv   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr    <= '0;
            r_rptr    <= '0;
            r_ram_cnt <= '0;
            r_cnt     <= '0;
            r_rd_pend <= 1'b0;
            r_ov      <= 1'b0;
            r_sv      <= 1'b0;
        end else begin
            r_wptr    <= r_wptr + QA_W'(i_wr_valid);
            r_rptr    <= r_rptr + QA_W'(rd_en);
            r_ram_cnt <= r_ram_cnt + CNT_W'(i_wr_valid) - CNT_W'(rd_en);
            r_cnt     <= r_cnt + CNT_W'(i_acc) - CNT_W'(pop);
            r_rd_pend <= rd_en;
            r_ov      <= n_ov;
            r_sv      <= n_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_room   = (r_cnt < CNT_W'(QDEPTH));
    assign o_tvalid = r_ov;
    assign o_data   = r_out;

    `ASSERT_CLK(a_credit_max, i_clk, i_rst_n, r_cnt <= CNT_W'(QDEPTH))
    `ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_wr_valid && (r_ram_cnt == CNT_W'(QDEPTH)))
    `ASSERT_CLK(a_rd_nonempty, i_clk, i_rst_n, rd_en |-> (r_ram_cnt != '0))
    `ASSERT_CLK(a_skid_behind_out, i_clk, i_rst_n, r_sv |-> r_ov)

endmodule

>>> hw/rtl/env_sensor_compensation.sv
// ----------------------------------------------------------------------------
// env_sensor_compensation
// integer compensation of combined temperature, pressure and humidity samples
//
// one raw sample (pressure, temperature, humidity conversions) enters on the
// slave stream; one compensated result leaves on the master stream with
// temperature in 0.01 degC, pressure in Pa and humidity in 0.01 %rH, and
// tuser set when the sensor is not marked ready (all values then zero).
// calibration coefficients and the two flags are written over the apb port;
// the user must write them only while no sample is in flight, which the block
// does not enforce. a register is at byte address 8 * index. a sample passes
// the front arithmetic stages, the pipelined pressure divider, the post-divide
// stages and the result queue read. one sample is accepted every cycle while
// the slave side is ready. results wait in a 128-entry queue, and the slave
// side stays ready while fewer than 128 samples are in flight or waiting, so
// a stalled receiver halts input once 128 are. synchronous reset clears the
// pipeline valid flags, queue pointers and counts and the apb registers to 0.
// ----------------------------------------------------------------------------
module env_sensor_compensation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [55:0] i_s_axis_tdata,   // adc_pressure, adc_temperature, adc_humidity
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [79:0] o_m_axis_tdata,   // temperature_centi, pressure, humidity
    output logic [0:0]  o_m_axis_tuser,   // status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import esc_pkg::*;

    logic [47:0] r_cfg_t;
    logic [63:0] r_cfg_pl;
    logic [63:0] r_cfg_ph;
    logic [47:0] r_cfg_m;
    logic [39:0] r_cfg_h;
    logic        r_hum_en;
    logic        r_ready;
    t_coef       coef;
    t_reg        idx;
    logic        wr;
    logic        acc;
    logic        fr_v;
    t_dvin       fr_d;
    logic        dv_v;
    t_dv         dv_d;
    logic        po_v;
    t_res        po_d;
    t_res        out_d;

    assign idx    = t_reg'(paddr[5:3]);
    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_t  <= '0;
            r_cfg_pl <= '0;
            r_cfg_ph <= '0;
            r_cfg_m  <= '0;
            r_cfg_h  <= '0;
            r_hum_en <= 1'b0;
            r_ready  <= 1'b0;
        end else if (wr) begin
            case (idx)
                REG_TEMP:     r_cfg_t  <= pwdata[47:0];
                REG_PRESS_LO: r_cfg_pl <= pwdata;
                REG_PRESS_HI: r_cfg_ph <= pwdata;
                REG_MIXED:    r_cfg_m  <= pwdata[47:0];
                REG_HUM:      r_cfg_h  <= pwdata[39:0];
                REG_HUM_EN:   r_hum_en <= pwdata[0];
                REG_READY:    r_ready  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_TEMP:     prdata = {16'd0, r_cfg_t};
            REG_PRESS_LO: prdata = r_cfg_pl;
            REG_PRESS_HI: prdata = r_cfg_ph;
            REG_MIXED:    prdata = {16'd0, r_cfg_m};
            REG_HUM:      prdata = {24'd0, r_cfg_h};
            REG_HUM_EN:   prdata = {63'd0, r_hum_en};
            REG_READY:    prdata = {63'd0, r_ready};
            default:      prdata = '0;
        endcase
    end

    assign coef.t1     = r_cfg_t[15:0];
    assign coef.t2     = r_cfg_t[31:16];
    assign coef.t3     = r_cfg_t[47:32];
    assign coef.p1     = r_cfg_pl[15:0];
    assign coef.p2     = r_cfg_pl[31:16];
    assign coef.p3     = r_cfg_pl[47:32];
    assign coef.p4     = r_cfg_pl[63:48];
    assign coef.p5     = r_cfg_ph[15:0];
    assign coef.p6     = r_cfg_ph[31:16];
    assign coef.p7     = r_cfg_ph[47:32];
    assign coef.p8     = r_cfg_ph[63:48];
    assign coef.p9     = r_cfg_m[15:0];
    assign coef.h1     = r_cfg_m[23:16];
    assign coef.h2     = r_cfg_m[39:24];
    assign coef.h3     = r_cfg_m[47:40];
    assign coef.h4     = r_cfg_h[15:0];
    assign coef.h5     = r_cfg_h[31:16];
    assign coef.h6     = r_cfg_h[39:32];
    assign coef.hum_en = r_hum_en;
    assign coef.ready  = r_ready;

    assign acc = i_s_axis_tvalid & o_s_axis_tready;

    esc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_v     (acc),
        .i_data  (t_in'(i_s_axis_tdata)),
        .i_coef  (coef),
        .o_v     (fr_v),
        .o_data  (fr_d)
    );

    esc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_v     (fr_v),
        .i_data  (fr_d),
        .o_v     (dv_v),
        .o_data  (dv_d)
    );

    esc_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_v     (dv_v),
        .i_data  (dv_d),
        .i_coef  (coef),
        .o_v     (po_v),
        .o_data  (po_d)
    );

    esc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (acc),
        .i_wr_valid (po_v),
        .i_wr_data  (po_d),
        .o_room     (o_s_axis_tready),
        .o_tvalid   (o_m_axis_tvalid),
        .i_tready   (i_m_axis_tready),
        .o_data     (out_d)
    );

    assign o_m_axis_tdata = {2'b00, out_d.hum, out_d.press, out_d.temp};
    assign o_m_axis_tuser = out_d.status;

endmodule

>>> tb/tb_env_sensor_compensation.sv
// ----------------------------------------------------------------------------
// tb_env_sensor_compensation
// self-checking bench for the sensor compensation block
//
// coefficient sets are written over apb between phases while the block is
// idle; raw samples are streamed with random gaps and receiver stalls, and
// every result is checked against an in-bench integer compensation model.
// ----------------------------------------------------------------------------
module tb_env_sensor_compensation;
    timeunit 1ns;
    timeprecision 1ps;
    import esc_pkg::*;

    class compensation_scoreboard;
        logic [63:0] coef_regs [7];
        logic [79:0] want_data [$];
        logic        want_user [$];
        int          mismatches;

        function new();
            foreach (coef_regs[i]) coef_regs[i] = '0;
            mismatches = 0;
        endfunction

        function automatic logic [31:0] shr32(logic [31:0] x, int n);
            logic signed [31:0] s;
            s = x;
            return s >>> n;
        endfunction

        function automatic logic [63:0] shr64(logic [63:0] x, int n);
            logic signed [63:0] s;
            s = x;
            return s >>> n;
        endfunction

        function automatic logic [63:0] quot64(logic [63:0] num, logic [63:0] den);
            logic [63:0] a;
            logic [63:0] b;
            logic [63:0] q;
            a = num[63] ? -num : num;
            b = den[63] ? -den : den;
            q = a / b;
            return (num[63] != den[63]) ? -q : q;
        endfunction

        function automatic logic [31:0] se16(logic [15:0] v);
            return {{16{v[15]}}, v};
        endfunction

        function automatic logic [63:0] se16w(logic [15:0] v);
            return {{48{v[15]}}, v};
        endfunction

        function void note_sample(logic [19:0] ap, logic [19:0] at, logic [15:0] ah);
            logic [31:0] t1, t2, t3, ta, td, tb, fine, temp, x, ha, hb, hum;
            logic [63:0] u, v, p, lo, hi;
            logic [31:0] press;
            if (coef_regs[REG_READY][0] == 1'b0) begin
                want_data.push_back('0);
                want_user.push_back(1'b1);
                return;
            end
            t1 = {16'd0, coef_regs[REG_TEMP][15:0]};
            t2 = se16(coef_regs[REG_TEMP][31:16]);
            t3 = se16(coef_regs[REG_TEMP][47:32]);
            ta = shr32(((at >> 3) - (t1 << 1)) * t2, 11);
            td = (at >> 4) - t1;
            tb = shr32(shr32(td * td, 12) * t3, 14);
            fine = ta + tb;
            temp = shr32(fine * 5 + 128, 8);
            lo = coef_regs[REG_PRESS_LO];
            hi = coef_regs[REG_PRESS_HI];
            u = {{32{fine[31]}}, fine} - 64'd128000;
            v = u * u * se16w(hi[31:16]);
            v = v + ((u * se16w(hi[15:0])) << 17);
            v = v + (se16w(lo[63:48]) << 35);
            u = shr64(u * u * se16w(lo[47:32]), 8) + ((u * se16w(lo[31:16])) << 12);
            u = shr64(((64'd1 << 47) + u) * {48'd0, lo[15:0]}, 33);
            if (u == 0) begin
                press = 0;
            end else begin
                p = 64'd1048576 - {44'd0, ap};
                p = quot64(((p << 31) - v) * 64'd3125, u);
                u = shr64(se16w(coef_regs[REG_MIXED][15:0]) * shr64(p, 13) * shr64(p, 13), 25);
                v = shr64(se16w(hi[63:48]) * p, 19);
                p = shr64(p + u + v, 8) + (se16w(hi[47:32]) << 4);
                press = quot64(p, 64'd256);
            end
            hum = 0;
            if (coef_regs[REG_HUM_EN][0]) begin
                x = fine - 32'd76800;
                ha = shr32(({16'd0, ah} << 14) - (se16(coef_regs[REG_HUM][15:0]) << 20)
                     - se16(coef_regs[REG_HUM][31:16]) * x + 32'd16384, 15);
                hb = shr32(x * {{24{coef_regs[REG_HUM][39]}}, coef_regs[REG_HUM][39:32]}, 10)
                     * (shr32(x * {24'd0, coef_regs[REG_MIXED][47:40]}, 11) + 32'd32768);
                hb = shr32(hb, 10) + 32'd2097152;
                hb = shr32(hb * se16(coef_regs[REG_MIXED][39:24]) + 32'd8192, 14);
                x = ha * hb;
                x = x - shr32(shr32(shr32(x, 15) * shr32(x, 15), 7)
                     * {24'd0, coef_regs[REG_MIXED][23:16]}, 4);
                if (x[31]) x = 0;
                else if (x > 32'd419430400) x = 32'd419430400;
                hum = ((x >> 12) * 100) / 1024;
            end
            want_data.push_back({2'b00, hum[13:0], press, temp});
            want_user.push_back(1'b0);
        endfunction

        function void check_result(logic [79:0] d, logic u);
            logic [79:0] e;
            logic eu;
            if (want_data.size() == 0) begin
                $error("result transfer with nothing expected");
                mismatches++;
                return;
            end
            e = want_data.pop_front();
            eu = want_user.pop_front();
            if (d[31:0] !== e[31:0]) begin
                $error("temperature_centi exp %0d got %0d", $signed(e[31:0]), $signed(d[31:0]));
                mismatches++;
            end
            if (d[63:32] !== e[63:32]) begin
                $error("pressure exp %0d got %0d", e[63:32], d[63:32]);
                mismatches++;
            end
            if (d[77:64] !== e[77:64]) begin
                $error("humidity exp %0d got %0d", e[77:64], d[77:64]);
                mismatches++;
            end
            if (u !== eu) begin
                $error("status exp %0d got %0d", eu, u);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    compensation_scoreboard sb;
    int unsigned cycle_count = 0;
    bit          stall_free;

    env_sensor_compensation u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready), .i_s_axis_tdata(s_tdata),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready), .o_m_axis_tdata(m_tdata),
        .o_m_axis_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // receiver stalls
    initial begin
        int g;
        m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_free) begin
                m_tready <= 1'b1;
            end else begin
                g = gap_len();
                m_tready <= (g == 0);
                repeat (g) @(posedge i_clk);
                if (g != 0) m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser[0]);
        if (cycle_count > 2000000) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_reg(t_reg idx, logic [63:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TEMP, REG_MIXED: sb.coef_regs[idx] = val & 64'hFFFF_FFFF_FFFF;
            REG_HUM:             sb.coef_regs[idx] = val & 64'hFF_FFFF_FFFF;
            REG_HUM_EN, REG_READY: sb.coef_regs[idx] = val & 64'd1;
            default:             sb.coef_regs[idx] = val;
        endcase
    endtask

    task automatic send_sample(logic [19:0] ap, logic [19:0] at, logic [15:0] ah, bit gaps);
        int g;
        s_tvalid <= 1'b1;
        s_tdata  <= {ah, at, ap};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sb.note_sample(ap, at, ah);
        g = gaps ? gap_len() : 0;
        if (g != 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.want_data.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    // datasheet-like coefficient set
    task automatic typical_coeffs();
        write_reg(REG_TEMP,     {16'd0, 16'd50, 16'd26435, 16'd27504});
        write_reg(REG_PRESS_LO, {16'd2855, 16'hD0D0, 16'hD67E, 16'd36477});
        write_reg(REG_PRESS_HI, {16'hC0C1, 16'd15500, 16'hFFF9, 16'd140});
        write_reg(REG_MIXED,    {16'd0, 8'd0, 16'd370, 8'd75, 16'd6000});
        write_reg(REG_HUM,      {24'd0, 8'd30, 16'd50, 16'd300});
    endtask

    task automatic random_coeffs();
        write_reg(REG_TEMP,     {$urandom, $urandom});
        write_reg(REG_PRESS_LO, {$urandom, $urandom});
        write_reg(REG_PRESS_HI, {$urandom, $urandom});
        write_reg(REG_MIXED,    {$urandom, $urandom});
        write_reg(REG_HUM,      {$urandom, $urandom});
    endtask

    task automatic random_burst(int n, bit near);
        bit gaps;
        for (int i = 0; i < n; i++) begin
            gaps = (i % 200) >= 60;
            if (near)
                send_sample(20'($urandom_range(250000, 450000)),
                            20'($urandom_range(480000, 560000)),
                            16'($urandom_range(20000, 40000)), gaps);
            else
                send_sample(20'($urandom), 20'($urandom), 16'($urandom), gaps);
        end
    endtask

    initial begin
        sb = new();
        stall_free = 1'b0;
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // not ready, every value zero
        send_sample(20'hFFFFF, 20'h00000, 16'hFFFF, 1'b0);
        send_sample(20'h00000, 20'hFFFFF, 16'h0000, 1'b0);
        drain();
        write_reg(REG_READY, 64'd1);
        // all coefficients zero: zero pressure divisor
        send_sample(20'd415148, 20'd519888, 16'd30000, 1'b0);
        drain();
        typical_coeffs();
        send_sample(20'd415148, 20'd519888, 16'd30000, 1'b0);
        drain();
        write_reg(REG_HUM_EN, 64'd1);
        send_sample(20'd415148, 20'd519888, 16'd30000, 1'b0);
        send_sample(20'd0, 20'd0, 16'd0, 1'b0);
        send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b0);
        send_sample(20'hFFFFF, 20'd0, 16'hFFFF, 1'b0);
        send_sample(20'd0, 20'hFFFFF, 16'd0, 1'b0);
        send_sample(20'd415148, 20'd519888, 16'hFFFF, 1'b0);
        send_sample(20'd415148, 20'd519888, 16'd0, 1'b0);
        drain();
        write_reg(REG_TEMP,     64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_PRESS_LO, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_PRESS_HI, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_MIXED,    64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_HUM,      64'hFFFF_FFFF_FFFF_FFFF);
        send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b0);
        send_sample(20'd0, 20'd0, 16'd0, 1'b0);
        send_sample(20'h80000, 20'h80000, 16'h8000, 1'b0);
        drain();
        write_reg(REG_TEMP,     64'h8000_8000_0000);
        write_reg(REG_PRESS_LO, 64'h8000_8000_8000_0001);
        write_reg(REG_PRESS_HI, 64'h8000_8000_8000_8000);
        write_reg(REG_MIXED,    64'hFF_8000_FF_8000);
        write_reg(REG_HUM,      64'h80_8000_8000);
        send_sample(20'h12345, 20'hFFFFF, 16'hFFFF, 1'b0);
        send_sample(20'hFFFFF, 20'd0, 16'd0, 1'b0);
        drain();

        typical_coeffs();
        random_burst(500, 1'b1);
        drain();
        write_reg(REG_HUM_EN, 64'd0);
        random_burst(200, 1'b0);
        drain();
        write_reg(REG_HUM_EN, 64'd1);
        for (int ph = 0; ph < 4; ph++) begin
            random_coeffs();
            random_burst(200, 1'b0);
            drain();
        end
        typical_coeffs();
        stall_free = 1'b1;
        random_burst(300, 1'b1);
        drain();
        stall_free = 1'b0;
        write_reg(REG_READY, 64'd0);
        random_burst(100, 1'b0);
        drain();
        write_reg(REG_READY, 64'd1);
        random_burst(50, 1'b1);
        drain();

        if (sb.mismatches == 0 && sb.want_data.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
